>>> hdl/erv_pkg.sv
`timescale 1ns / 1ps
package erv_pkg;

    localparam int TRIG_STAGES = 16;
    localparam int TRIG_LAT    = TRIG_STAGES + 3;

    localparam int VEC_W   = 36;
    localparam int CS_W    = 32;
    localparam int PROD_W  = VEC_W + CS_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int CX_W    = 33;
    localparam int CZ_W    = 34;
    localparam int MAG_W   = 31;
    localparam int SQ_W    = 64;
    localparam int SQRT_STEPS = 32;
    localparam int LEN_W   = 32;
    localparam int Q_W     = 15;
    localparam int FRAC_SH = 14;
    localparam int REM_W   = 47;
    localparam int OUT_W   = 16;
    localparam int RES_W   = 3 * OUT_W + 1;

    localparam logic [1:0] REG_ANGLE_X = 2'd0;
    localparam logic [1:0] REG_ANGLE_Y = 2'd1;
    localparam logic [1:0] REG_ANGLE_Z = 2'd2;

    localparam logic signed [CX_W-1:0] CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic [1:0]              axis;
        logic                    flip;
        logic signed [CX_W-1:0]  x;
        logic signed [CX_W-1:0]  y;
        logic signed [CZ_W-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } side_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        side_t           side;
    } sqrt_t;

    typedef struct packed {
        logic [2:0][REM_W-1:0] rem;
        logic [2:0][Q_W-1:0]   quo;
        logic [LEN_W-1:0]      len;
        logic [2:0]            neg;
        logic                  zero;
    } div_t;

    // arctan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/euler_rotate_normalize_vector_core.sv
`timescale 1ns / 1ps
// Euler X-Y-Z rotation of a Q16.16 vector, normalized to a Q2.14 unit vector.
// Channels: s_ (input vector) and m_ (unit vector + zero flag) stream groups,
// plus a cfg_ write channel for the three angles (degrees * 64).
// Throughput: one vector per cycle outside a trig refresh; the datapath is a
// row of cells (three rotation cells, normalize shift steps, 32 square-root
// cells, 15 divide cells), every one advancing together whenever the output
// buffer has room. Sine and cosine come from a 16-cell CORDIC row that runs
// once per angle after reset and after every cfg write; s_tready stays low
// while it refreshes. cfg_ready is always high.
// Reset: angles clear to zero, the pipeline empties, the trig refresh starts.
// Stall: a two-entry output buffer holds results; input keeps flowing while
// one result waits; the whole row holds while both are full and m_tready low.
module euler_rotate_normalize_vector_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_x[15:0], out_y[31:16], out_z[47:32]
    output logic [0:0]  m_tuser,   // zero_length[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import erv_pkg::*;

    localparam int PIPE   = 65;
    localparam int TDONE  = TRIG_LAT + 4;
    localparam int TCNT_W = $clog2(TDONE + 1);

    // ---------------- configuration ----------------
    logic [15:0] angle_reg [3];
    logic        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg[0] <= '0;
            angle_reg[1] <= '0;
            angle_reg[2] <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_ANGLE_X: angle_reg[0] <= cfg_data;
                REG_ANGLE_Y: angle_reg[1] <= cfg_data;
                REG_ANGLE_Z: angle_reg[2] <= cfg_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // ---------------- trig refresh control ----------------
    logic              busy_reg, busy_next;
    logic [TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic              inject;
    logic [TRIG_LAT-1:0] tv_reg;

    always_comb begin
        busy_next = busy_reg;
        tcnt_next = tcnt_reg;
        if (cfg_wr) begin
            busy_next = 1'b1;
            tcnt_next = '0;
        end else if (busy_reg) begin
            if (tcnt_reg == TCNT_W'(TDONE)) begin
                busy_next = 1'b0;
            end else begin
                tcnt_next = tcnt_reg + 1'b1;
            end
        end
    end

    assign inject = busy_reg && (tcnt_reg < TCNT_W'(3));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            tcnt_reg <= '0;
            tv_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            tcnt_reg <= tcnt_next;
            tv_reg   <= {tv_reg[TRIG_LAT-2:0], inject};
        end
    end

    // angle reduction: negate, wrap into (-180, 180], fold into +-90
    logic [15:0]        code;
    logic signed [17:0] neg_a, wrap_a, fold_a;
    logic               fold_flip;
    logic [12:0]        p1_mag_reg;
    logic               p1_neg_reg, p1_flip_reg;
    logic [1:0]         p1_axis_reg;

    always_comb begin
        unique case (tcnt_reg[1:0])
            REG_ANGLE_X: code = angle_reg[0];
            REG_ANGLE_Y: code = angle_reg[1];
            default:     code = angle_reg[2];
        endcase
        neg_a = 18'sd0 - $signed({{2{code[15]}}, code});
        if (neg_a > 18'sd11520) begin
            wrap_a = neg_a - 18'sd23040;
        end else if (neg_a <= -18'sd11520) begin
            wrap_a = neg_a + 18'sd23040;
        end else begin
            wrap_a = neg_a;
        end
        fold_flip = 1'b1;
        if (wrap_a > 18'sd5760) begin
            fold_a = wrap_a - 18'sd11520;
        end else if (wrap_a < -18'sd5760) begin
            fold_a = wrap_a + 18'sd11520;
        end else begin
            fold_a    = wrap_a;
            fold_flip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        p1_neg_reg  <= fold_a[17];
        p1_mag_reg  <= fold_a[17] ? 13'(18'sd0 - fold_a) : fold_a[12:0];
        p1_flip_reg <= fold_flip;
        p1_axis_reg <= tcnt_reg[1:0];
    end

    // radians: z = round(mag * pi/4 / 2880) in Q2.30, split into an exact
    // integer part and a remainder divided by 2880 through a reciprocal
    logic [30:0] p2_base_reg;
    logic [17:0] p2_frac_reg;
    logic        p2_neg_reg, p2_flip_reg;
    logic [1:0]  p2_axis_reg;
    logic [23:0] frac_num;
    logic [36:0] frac_prod;
    logic [30:0] z_mag;
    cordic_t     cc [TRIG_STAGES+1];
    cordic_t     p3_reg;

    assign frac_num = {11'd0, p1_mag_reg} * 24'd1896 + 24'd1440;

    always_ff @(posedge aclk) begin
        p2_base_reg <= {18'd0, p1_mag_reg} * 31'd292817;
        p2_frac_reg <= frac_num[23:6];
        p2_neg_reg  <= p1_neg_reg;
        p2_flip_reg <= p1_flip_reg;
        p2_axis_reg <= p1_axis_reg;
    end

    assign frac_prod = {19'd0, p2_frac_reg} * 37'd372828;
    assign z_mag     = p2_base_reg + {18'd0, frac_prod[36:24]};

    always_ff @(posedge aclk) begin
        p3_reg.axis <= p2_axis_reg;
        p3_reg.flip <= p2_flip_reg;
        p3_reg.x    <= CORDIC_GAIN;
        p3_reg.y    <= '0;
        p3_reg.z    <= p2_neg_reg ? (CZ_W'(0) - {3'b000, z_mag}) : {3'b000, z_mag};
    end

    assign cc[0] = p3_reg;

    for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_cordic
        erv_cordic_cell u_cell (
            .aclk  (aclk),
            .idx   (5'(k)),
            .c_in  (cc[k]),
            .c_out (cc[k+1])
        );
    end

    // capture cosine/sine per axis, undo the half-turn fold
    logic signed [CS_W-1:0] cos_reg [3];
    logic signed [CS_W-1:0] sin_reg [3];
    logic signed [CX_W-1:0] cap_x, cap_y;

    always_comb begin
        cap_x = cc[TRIG_STAGES].flip ? -cc[TRIG_STAGES].x : cc[TRIG_STAGES].x;
        cap_y = cc[TRIG_STAGES].flip ? -cc[TRIG_STAGES].y : cc[TRIG_STAGES].y;
    end

    always_ff @(posedge aclk) begin
        if (tv_reg[TRIG_LAT-1]) begin
            unique case (cc[TRIG_STAGES].axis)
                REG_ANGLE_X: begin
                    cos_reg[0] <= cap_x[CS_W-1:0];
                    sin_reg[0] <= cap_y[CS_W-1:0];
                end
                REG_ANGLE_Y: begin
                    cos_reg[1] <= cap_x[CS_W-1:0];
                    sin_reg[1] <= cap_y[CS_W-1:0];
                end
                REG_ANGLE_Z: begin
                    cos_reg[2] <= cap_x[CS_W-1:0];
                    sin_reg[2] <= cap_y[CS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath flow control ----------------
    logic            en, s_acc;
    logic [PIPE-1:0] vld_reg;
    logic [1:0]      sk_cnt_reg;

    assign en       = (sk_cnt_reg != 2'd2) || m_tready;
    assign s_tready = en && !busy_reg;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE-2:0], s_acc};
        end
    end

    // input register
    logic signed [VEC_W-1:0] vx_reg, vy_reg, vz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg <= {{(VEC_W-32){s_tdata[31]}}, s_tdata[31:0]};
            vy_reg <= {{(VEC_W-32){s_tdata[63]}}, s_tdata[63:32]};
            vz_reg <= {{(VEC_W-32){s_tdata[95]}}, s_tdata[95:64]};
        end
    end

    // rotations about X, Y, Z
    logic signed [VEC_W-1:0] rx_a, rx_b, rx_p, ry_a, ry_b, ry_p, rz_a, rz_b, rz_p;

    erv_rot_cell u_rot_x (
        .aclk(aclk), .en(en), .a_in(vy_reg), .b_in(vz_reg), .p_in(vx_reg),
        .cos_in(cos_reg[0]), .sin_in(sin_reg[0]),
        .a_out(rx_a), .b_out(rx_b), .p_out(rx_p)
    );

    erv_rot_cell u_rot_y (
        .aclk(aclk), .en(en), .a_in(rx_b), .b_in(rx_p), .p_in(rx_a),
        .cos_in(cos_reg[1]), .sin_in(sin_reg[1]),
        .a_out(ry_a), .b_out(ry_b), .p_out(ry_p)
    );

    erv_rot_cell u_rot_z (
        .aclk(aclk), .en(en), .a_in(ry_b), .b_in(ry_p), .p_in(ry_a),
        .cos_in(cos_reg[2]), .sin_in(sin_reg[2]),
        .a_out(rz_a), .b_out(rz_b), .p_out(rz_p)
    );

    // magnitudes and signs: x = rz_a, y = rz_b, z = rz_p
    logic [VEC_W-1:0] fin [3];
    logic [VEC_W-1:0] n1_mag_reg [3];
    logic [2:0]       n1_neg_reg;
    logic             n1_zero_reg;

    assign fin[0] = rz_a;
    assign fin[1] = rz_b;
    assign fin[2] = rz_p;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                n1_neg_reg[j] <= fin[j][VEC_W-1];
                n1_mag_reg[j] <= fin[j][VEC_W-1] ? (~fin[j] + VEC_W'(1)) : fin[j];
            end
            n1_zero_reg <= (fin[0] == '0) && (fin[1] == '0) && (fin[2] == '0);
        end
    end

    // largest magnitude
    logic [VEC_W-1:0] n2_mag_reg [3];
    logic [VEC_W-1:0] n2_mx_reg, mx01;
    logic [2:0]       n2_neg_reg;
    logic             n2_zero_reg;

    assign mx01 = (n1_mag_reg[0] > n1_mag_reg[1]) ? n1_mag_reg[0] : n1_mag_reg[1];

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_mag_reg  <= n1_mag_reg;
            n2_mx_reg   <= (n1_mag_reg[2] > mx01) ? n1_mag_reg[2] : mx01;
            n2_neg_reg  <= n1_neg_reg;
            n2_zero_reg <= n1_zero_reg;
        end
    end

    // right shift so the largest is below 2^31
    logic [2:0]       rsh;
    logic [VEC_W-1:0] rs_mx;
    logic [VEC_W-1:0] rs_mag [3];
    logic [MAG_W-1:0] lmag_reg [6][3];
    logic [MAG_W-1:0] lmx_reg  [6];
    logic [2:0]       lneg_reg [6];
    logic             lzero_reg [6];

    always_comb begin
        priority if (n2_mx_reg[35]) rsh = 3'd5;
        else if (n2_mx_reg[34])     rsh = 3'd4;
        else if (n2_mx_reg[33])     rsh = 3'd3;
        else if (n2_mx_reg[32])     rsh = 3'd2;
        else if (n2_mx_reg[31])     rsh = 3'd1;
        else                        rsh = 3'd0;
        rs_mx = n2_mx_reg >> rsh;
        for (int j = 0; j < 3; j++) begin
            rs_mag[j] = n2_mag_reg[j] >> rsh;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lmx_reg[0] <= rs_mx[MAG_W-1:0];
            for (int j = 0; j < 3; j++) begin
                lmag_reg[0][j] <= rs_mag[j][MAG_W-1:0];
            end
            lneg_reg[0]  <= n2_neg_reg;
            lzero_reg[0] <= n2_zero_reg;
        end
    end

    // left shift steps of 16, 8, 4, 2, 1 until bit 30 of the largest is set
    for (genvar k = 0; k < 5; k++) begin : g_lsh
        localparam int SH = 16 >> k;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (lmx_reg[k][MAG_W-1 -: SH] == '0) begin
                    lmx_reg[k+1] <= lmx_reg[k] << SH;
                    for (int j = 0; j < 3; j++) begin
                        lmag_reg[k+1][j] <= lmag_reg[k][j] << SH;
                    end
                end else begin
                    lmx_reg[k+1]  <= lmx_reg[k];
                    lmag_reg[k+1] <= lmag_reg[k];
                end
                lneg_reg[k+1]  <= lneg_reg[k];
                lzero_reg[k+1] <= lzero_reg[k];
            end
        end
    end

    // squares, then their sum
    logic [2*MAG_W-1:0] sq_reg [3];
    side_t              q1_side_reg;
    sqrt_t              sq [SQRT_STEPS+1];
    sqrt_t              q2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                sq_reg[j]            <= {{MAG_W{1'b0}}, lmag_reg[5][j]}
                                      * {{MAG_W{1'b0}}, lmag_reg[5][j]};
                q1_side_reg.mag[j]   <= lmag_reg[5][j];
            end
            q1_side_reg.neg  <= lneg_reg[5];
            q1_side_reg.zero <= lzero_reg[5];
            q2_reg.rem  <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
            q2_reg.root <= '0;
            q2_reg.side <= q1_side_reg;
        end
    end

    assign sq[0] = q2_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        erv_sqrt_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .idx   (5'(k)),
            .s_in  (sq[k]),
            .s_out (sq[k+1])
        );
    end

    // dividend = mag * 2^14 + len / 2, rounding the quotient to nearest
    div_t             dv [Q_W+1];
    div_t             d0_reg;
    logic [LEN_W-1:0] len;

    assign len = sq[SQRT_STEPS].root[LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                d0_reg.rem[j] <= {2'b00, sq[SQRT_STEPS].side.mag[j], {FRAC_SH{1'b0}}}
                               + {{(REM_W-LEN_W+1){1'b0}}, len[LEN_W-1:1]};
                d0_reg.quo[j] <= '0;
            end
            d0_reg.len  <= len;
            d0_reg.neg  <= sq[SQRT_STEPS].side.neg;
            d0_reg.zero <= sq[SQRT_STEPS].side.zero;
        end
    end

    assign dv[0] = d0_reg;

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        erv_div_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .idx   (4'(Q_W - 1 - k)),
            .d_in  (dv[k]),
            .d_out (dv[k+1])
        );
    end

    // sign, zero-length override
    logic [OUT_W-1:0] res_c [3];
    logic [RES_W-1:0] res;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (dv[Q_W].zero) begin
                res_c[j] = '0;
            end else if (dv[Q_W].neg[j]) begin
                res_c[j] = OUT_W'(0) - {1'b0, dv[Q_W].quo[j]};
            end else begin
                res_c[j] = {1'b0, dv[Q_W].quo[j]};
            end
        end
        res = {dv[Q_W].zero, res_c[2], res_c[1], res_c[0]};
    end

    // ---------------- two-entry output buffer ----------------
    logic [RES_W-1:0] sk0_reg, sk1_reg;
    logic             push, pop;

    assign push = en && vld_reg[PIPE-1];
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sk_cnt_reg <= '0;
        end else begin
            sk_cnt_reg <= sk_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (sk_cnt_reg == 2'd2) begin
                sk0_reg <= sk1_reg;
                if (push) begin
                    sk1_reg <= res;
                end
            end else if (push) begin
                sk0_reg <= res;
            end
        end else if (push) begin
            if (sk_cnt_reg == 2'd0) begin
                sk0_reg <= res;
            end else begin
                sk1_reg <= res;
            end
        end
    end

    assign m_tvalid = (sk_cnt_reg != 2'd0);
    assign m_tdata  = sk0_reg[3*OUT_W-1:0];
    assign m_tuser  = sk0_reg[RES_W-1 -: 1];

    // ---------------- assertions ----------------
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero-length result carries nonzero components");

    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("input taken during trig refresh");

    a_cfg_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> busy_reg)
        else $error("cfg transfer did not start a trig refresh");

    a_buf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_cnt_reg != 2'd3)
        else $error("output buffer overflow");

endmodule

>>> hdl/erv_cordic_cell.sv
`timescale 1ns / 1ps
module erv_cordic_cell (
    input  logic             aclk,
    input  logic [4:0]       idx,
    input  erv_pkg::cordic_t c_in,
    output erv_pkg::cordic_t c_out
);
    import erv_pkg::*;

    cordic_t                c_reg, c_next;
    logic signed [CX_W-1:0] x_i, y_i, dx, dy;
    logic signed [CZ_W-1:0] z_i, da;

    always_comb begin
        x_i = c_in.x;
        y_i = c_in.y;
        z_i = c_in.z;
        dx  = y_i >>> idx;
        dy  = x_i >>> idx;
        da  = {2'b00, atan_q30(idx)};
        c_next = c_in;
        if (!z_i[CZ_W-1]) begin
            c_next.x = x_i - dx;
            c_next.y = y_i + dy;
            c_next.z = z_i - da;
        end else begin
            c_next.x = x_i + dx;
            c_next.y = y_i - dy;
            c_next.z = z_i + da;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg <= c_next;
    end

    assign c_out = c_reg;

endmodule

>>> hdl/erv_rot_cell.sv
`timescale 1ns / 1ps
module erv_rot_cell (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [erv_pkg::VEC_W-1:0]    a_in,
    input  logic signed [erv_pkg::VEC_W-1:0]    b_in,
    input  logic signed [erv_pkg::VEC_W-1:0]    p_in,
    input  logic signed [erv_pkg::CS_W-1:0]     cos_in,
    input  logic signed [erv_pkg::CS_W-1:0]     sin_in,
    output logic signed [erv_pkg::VEC_W-1:0]    a_out,
    output logic signed [erv_pkg::VEC_W-1:0]    b_out,
    output logic signed [erv_pkg::VEC_W-1:0]    p_out
);
    import erv_pkg::*;

    // a' = a*c + b*s, b' = b*c - a*s, rounded then floor-shifted by 30
    logic signed [PROD_W-1:0] ac_reg, bs_reg, bc_reg, as_reg;
    logic signed [VEC_W-1:0]  p1_reg, a_reg, b_reg, p_reg;
    logic signed [SUM_W-1:0]  sum_a, sum_b, rnd;

    always_comb begin
        rnd   = SUM_W'(1) << 29;
        sum_a = {ac_reg[PROD_W-1], ac_reg} + {bs_reg[PROD_W-1], bs_reg} + rnd;
        sum_b = {bc_reg[PROD_W-1], bc_reg} - {as_reg[PROD_W-1], as_reg} + rnd;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ac_reg <= a_in * cos_in;
            bs_reg <= b_in * sin_in;
            bc_reg <= b_in * cos_in;
            as_reg <= a_in * sin_in;
            p1_reg <= p_in;
            a_reg  <= sum_a[VEC_W+29:30];
            b_reg  <= sum_b[VEC_W+29:30];
            p_reg  <= p1_reg;
        end
    end

    assign a_out = a_reg;
    assign b_out = b_reg;
    assign p_out = p_reg;

endmodule

>>> hdl/erv_sqrt_cell.sv
`timescale 1ns / 1ps
module erv_sqrt_cell (
    input  logic           aclk,
    input  logic           en,
    input  logic [4:0]     idx,
    input  erv_pkg::sqrt_t s_in,
    output erv_pkg::sqrt_t s_out
);
    import erv_pkg::*;

    sqrt_t           s_reg, s_next;
    logic [SQ_W-1:0] bit_w, trial;

    // one result bit per cell
    always_comb begin
        bit_w  = SQ_W'(1) << (6'd62 - {idx, 1'b0});
        trial  = s_in.root + bit_w;
        s_next = s_in;
        if (s_in.rem >= trial) begin
            s_next.rem  = s_in.rem - trial;
            s_next.root = (s_in.root >> 1) + bit_w;
        end else begin
            s_next.root = s_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= s_next;
        end
    end

    assign s_out = s_reg;

endmodule

>>> hdl/erv_div_cell.sv
`timescale 1ns / 1ps
module erv_div_cell (
    input  logic          aclk,
    input  logic          en,
    input  logic [3:0]    idx,
    input  erv_pkg::div_t d_in,
    output erv_pkg::div_t d_out
);
    import erv_pkg::*;

    div_t             d_reg, d_next;
    logic [REM_W-1:0] cmp;

    // one quotient bit per cell on all three lanes
    always_comb begin
        cmp    = {{(REM_W-LEN_W){1'b0}}, d_in.len} << idx;
        d_next = d_in;
        for (int j = 0; j < 3; j++) begin
            if (d_in.rem[j] >= cmp) begin
                d_next.rem[j] = d_in.rem[j] - cmp;
                d_next.quo[j] = d_in.quo[j] | (Q_W'(1) << idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule
